### rtl/rtc_pkg.sv
// Shared widths, codes, types and window helpers for the regression trend classifier.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
`default_nettype none

package rtc_pkg;

  localparam int SAMPLE_W      = 16;
  localparam int TREND_W       = 2;
  localparam int WIN_W         = 7;
  localparam int COORD_W       = 8;
  localparam int SPAN_W        = WIN_W + 1;
  localparam int SXY_W         = 28;
  localparam int SX2_W         = 17;
  localparam int FRACTION_BITS = 4;
  localparam int MAX_WINDOW    = 64;
  localparam int RHS_W         = SX2_W + FRACTION_BITS;
  localparam int LHS_W         = SXY_W + SPAN_W;
  localparam int DIGIT_W       = 2;
  localparam int MAC_DIGITS    = COORD_W / DIGIT_W;
  localparam int CMP_DIGITS    = SPAN_W / DIGIT_W;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 1;

  localparam logic [APB_AW-1:0] ADDR_WINDOW_SIZE = '0;
  localparam logic [WIN_W-1:0]  WINDOW_RESET     = 7'd8;
  localparam logic [WIN_W-1:0]  WINDOW_MIN       = 7'd2;
  localparam logic [WIN_W-1:0]  WINDOW_MAX       = WIN_W'(MAX_WINDOW);

  localparam logic signed [COORD_W-1:0] STEP_EVEN = 8'sd2;
  localparam logic signed [COORD_W-1:0] STEP_ODD  = 8'sd1;

  typedef logic [TREND_W-1:0] trend_t;

  localparam trend_t TREND_RISING  = 2'd0;
  localparam trend_t TREND_STEADY  = 2'd1;
  localparam trend_t TREND_FALLING = 2'd2;

  typedef struct packed {
    logic start;
    logic clear;
  } mac_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_sts_t;

  function automatic logic [WIN_W-1:0] eff_window(input logic [WIN_W-1:0] ws);
    if (ws < WINDOW_MIN) return WINDOW_MIN;
    else if (ws > WINDOW_MAX) return WINDOW_MAX;
    else return ws;
  endfunction

  function automatic logic signed [COORD_W-1:0] first_coord(input logic [WIN_W-1:0] n);
    logic [WIN_W-1:0]   nm1;
    logic [COORD_W-1:0] mag;
    nm1 = n - WIN_W'(1);
    if (n[0]) mag = COORD_W'(nm1 >> 1);
    else mag = COORD_W'(nm1);
    return -$signed(mag);
  endfunction

  function automatic logic [SPAN_W-1:0] window_span(input logic [WIN_W-1:0] n);
    logic [WIN_W-1:0] nm1;
    nm1 = n - WIN_W'(1);
    if (n[0]) return {1'b0, nm1};
    else return {nm1, 1'b0};
  endfunction

endpackage

`default_nettype wire

### rtl/rtc_if.sv
// Valid/ready word channels of the trend classifier: sample in, trend out.
// Depends on rtc_pkg for payload widths and the trend type.
`default_nettype none

interface rtc_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [rtc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface rtc_out_if;
  logic            valid;
  logic            ready;
  rtc_pkg::trend_t trend;

  modport source (output valid, output trend, input ready);
  modport sink (input valid, input trend, output ready);
endinterface

`default_nettype wire

### rtl/regression_trend_classifier_unit.sv
// Top level of the least-squares trend classifier: window sequencing, APB register,
// output word register. Depends on rtc_pkg, rtc_if, rtc_mac and rtc_cmp.
//
//   port group   dir   handshake          payload
//   in_ch        in    valid/ready        sample  s16 Q11.4
//   out_ch       out   valid/ready        trend   u2 (0 rising, 1 steady, 2 falling)
//   psel...      in    APB write/read     window_size u7 at byte address 0
//
// A sample word passes through the digit-serial MAC at 2 bits of x per cycle;
// a word that does not close a window lets the next word in on its last digit.
// The word that closes a window then goes through a launch state, the slope
// multiplier and compare unit, and the load of the output register.
// Synchronous active-low reset; no clearing pass. in_ch stalls while a window
// result waits for a full output register; out_ch back-pressure stalls nothing else.
`default_nettype none

module regression_trend_classifier_unit (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rtc_in_if.sink                             in_ch,
  rtc_out_if.source                          out_ch,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rtc_pkg::APB_AW-1:0]    paddr,
  input  wire logic [rtc_pkg::APB_DW-1:0]    pwdata,
  output logic [rtc_pkg::APB_DW-1:0]         prdata,
  output logic                               pready
);

  localparam int WIN_W   = rtc_pkg::WIN_W;
  localparam int COORD_W = rtc_pkg::COORD_W;
  localparam int APB_DW  = rtc_pkg::APB_DW;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MAC    = 3'd1;
  localparam logic [2:0] S_LAUNCH = 3'd2;
  localparam logic [2:0] S_CMP    = 3'd3;
  localparam logic [2:0] S_HOLD   = 3'd4;

  logic [2:0]                state_r, state_nxt;
  logic [WIN_W-1:0]          ws_r;
  logic [WIN_W-1:0]          count_r;
  logic signed [COORD_W-1:0] coord_r;
  logic                      win_end_r;
  logic                      out_valid_r;
  rtc_pkg::trend_t           out_trend_r;

  logic [WIN_W-1:0]          n_eff;
  logic [WIN_W-1:0]          cnt_inc;
  logic                      cfg_wr;
  logic                      accept;
  logic                      out_load;
  rtc_pkg::mac_ctl_t         mac_ctl;
  rtc_pkg::unit_sts_t        mac_sts;
  rtc_pkg::unit_sts_t        cmp_sts;
  logic                      cmp_start;
  logic signed [rtc_pkg::SXY_W-1:0] sum_xy;
  logic [rtc_pkg::SX2_W-1:0] sum_x2;
  rtc_pkg::trend_t           cmp_trend;

  assign n_eff   = rtc_pkg::eff_window(ws_r);
  assign cnt_inc = count_r + WIN_W'(1);
  assign cfg_wr  = psel && penable && pwrite && (paddr == rtc_pkg::ADDR_WINDOW_SIZE);
  assign pready  = 1'b1;
  assign prdata  = (paddr == rtc_pkg::ADDR_WINDOW_SIZE) ? APB_DW'(ws_r) : '0;

  // next word may enter on the MAC's last digit unless the current word closes the window
  assign in_ch.ready = (state_r == S_IDLE) ||
                       ((state_r == S_MAC) && mac_sts.done && !win_end_r);
  assign accept      = in_ch.valid && in_ch.ready;
  assign cmp_start   = (state_r == S_LAUNCH);
  assign out_load    = (state_r == S_HOLD) && (!out_valid_r || out_ch.ready);

  assign mac_ctl.start = accept;
  assign mac_ctl.clear = cfg_wr || cmp_start;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (accept) state_nxt = S_MAC;
      S_MAC: begin
        if (mac_sts.done) begin
          if (win_end_r) state_nxt = S_LAUNCH;
          else if (accept) state_nxt = S_MAC;
          else state_nxt = S_IDLE;
        end
      end
      S_LAUNCH: state_nxt = S_CMP;
      S_CMP:    if (cmp_sts.done) state_nxt = S_HOLD;
      S_HOLD:   if (out_load) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ws_r        <= rtc_pkg::WINDOW_RESET;
      count_r     <= '0;
      coord_r     <= rtc_pkg::first_coord(rtc_pkg::WINDOW_RESET);
      win_end_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr) begin
        ws_r    <= pwdata[WIN_W-1:0];
        count_r <= '0;
        coord_r <= rtc_pkg::first_coord(rtc_pkg::eff_window(pwdata[WIN_W-1:0]));
      end else if (accept) begin
        if (cnt_inc >= n_eff) begin
          win_end_r <= 1'b1;
          count_r   <= '0;
          coord_r   <= rtc_pkg::first_coord(n_eff);
        end else begin
          win_end_r <= 1'b0;
          count_r   <= cnt_inc;
          coord_r   <= coord_r + (n_eff[0] ? rtc_pkg::STEP_ODD : rtc_pkg::STEP_EVEN);
        end
      end
      if (out_load) out_valid_r <= 1'b1;
      else if (out_ch.ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) out_trend_r <= cmp_trend;
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.trend = out_trend_r;

  rtc_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctl    (mac_ctl),
    .sample (in_ch.sample),
    .coord  (coord_r),
    .sts    (mac_sts),
    .sum_xy (sum_xy),
    .sum_x2 (sum_x2)
  );

  rtc_cmp u_cmp (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (cmp_start),
    .sum_xy (sum_xy),
    .sum_x2 (sum_x2),
    .span   (rtc_pkg::window_span(n_eff)),
    .sts    (cmp_sts),
    .trend  (cmp_trend)
  );

  a_count_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    count_r < n_eff)
    else $error("sample count reached window size");

  a_mac_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    mac_sts.done |-> state_r == S_MAC)
    else $error("MAC finished outside MAC state");

  a_cmp_busy_state: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_sts.busy |-> state_r == S_CMP)
    else $error("slope unit busy outside compare state");

  a_launch_mac_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmp_start |-> !mac_sts.busy && !accept)
    else $error("slope launch while MAC active");

endmodule

`default_nettype wire

### rtl/rtc_mac.sv
// Digit-serial multiply-accumulate: sum_xy += sample*x and sum_x2 += x*x,
// two bits of x per cycle. Depends on rtc_pkg.
`default_nettype none

module rtc_mac (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire rtc_pkg::mac_ctl_t                    ctl,
  input  wire logic signed [rtc_pkg::SAMPLE_W-1:0]  sample,
  input  wire logic signed [rtc_pkg::COORD_W-1:0]   coord,
  output rtc_pkg::unit_sts_t                        sts,
  output logic signed [rtc_pkg::SXY_W-1:0]          sum_xy,
  output logic [rtc_pkg::SX2_W-1:0]                 sum_x2
);

  localparam int SXY_W   = rtc_pkg::SXY_W;
  localparam int SX2_W   = rtc_pkg::SX2_W;
  localparam int COORD_W = rtc_pkg::COORD_W;
  localparam int DIGIT_W = rtc_pkg::DIGIT_W;
  localparam int CNT_W   = $clog2(rtc_pkg::MAC_DIGITS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(rtc_pkg::MAC_DIGITS - 1);

  logic                      busy_r, busy_nxt;
  logic [CNT_W-1:0]          dcnt_r, dcnt_nxt;
  logic signed [COORD_W-1:0] xdig_r;
  logic signed [SXY_W-1:0]   ymc_r;
  logic signed [SX2_W-1:0]   xmc_r;
  logic signed [SXY_W-1:0]   sxy_r, sxy_nxt;
  logic [SX2_W-1:0]          sx2_r, sx2_nxt;
  logic                      last;
  logic signed [DIGIT_W:0]   sdig;
  logic signed [SXY_W-1:0]   term_xy;
  logic signed [SX2_W-1:0]   term_x2;

  // top digit of x carries the negative weight
  assign last    = busy_r && (dcnt_r == CNT_LAST);
  assign sdig    = last ? {xdig_r[DIGIT_W-1], xdig_r[DIGIT_W-1:0]}
                        : {1'b0, xdig_r[DIGIT_W-1:0]};
  assign term_xy = ymc_r * sdig;
  assign term_x2 = xmc_r * sdig;

  always_comb begin
    busy_nxt = ctl.start | (busy_r & ~last);
    dcnt_nxt = ctl.start ? '0 : (busy_r ? dcnt_r + CNT_W'(1) : dcnt_r);
    sxy_nxt  = sxy_r;
    sx2_nxt  = sx2_r;
    if (ctl.clear) begin
      sxy_nxt = '0;
      sx2_nxt = '0;
    end else if (busy_r) begin
      sxy_nxt = sxy_r + term_xy;
      sx2_nxt = sx2_r + unsigned'(term_x2);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      dcnt_r <= '0;
      sxy_r  <= '0;
      sx2_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      dcnt_r <= dcnt_nxt;
      sxy_r  <= sxy_nxt;
      sx2_r  <= sx2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      xdig_r <= coord;
      ymc_r  <= SXY_W'(sample);
      xmc_r  <= SX2_W'(coord);
    end else if (busy_r) begin
      xdig_r <= xdig_r >>> DIGIT_W;
      ymc_r  <= ymc_r <<< DIGIT_W;
      xmc_r  <= xmc_r <<< DIGIT_W;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = last;
  assign sum_xy   = sxy_r;
  assign sum_x2   = sx2_r;

endmodule

`default_nettype wire

### rtl/rtc_cmp.sv
// Digit-serial slope test: sum_xy*span against +/- sum_x2 scaled by the fraction,
// two bits of span per cycle, then one compare. Depends on rtc_pkg.
`default_nettype none

module rtc_cmp (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  input  wire logic signed [rtc_pkg::SXY_W-1:0]    sum_xy,
  input  wire logic [rtc_pkg::SX2_W-1:0]           sum_x2,
  input  wire logic [rtc_pkg::SPAN_W-1:0]          span,
  output rtc_pkg::unit_sts_t                       sts,
  output rtc_pkg::trend_t                          trend
);

  localparam int LHS_W   = rtc_pkg::LHS_W;
  localparam int RHS_W   = rtc_pkg::RHS_W;
  localparam int SPAN_W  = rtc_pkg::SPAN_W;
  localparam int DIGIT_W = rtc_pkg::DIGIT_W;
  localparam int CNT_W   = $clog2(rtc_pkg::CMP_DIGITS + 1);
  localparam logic [CNT_W-1:0] CNT_CMP = CNT_W'(rtc_pkg::CMP_DIGITS);

  logic                    busy_r;
  logic [CNT_W-1:0]        cnt_r;
  logic signed [LHS_W-1:0] mc_r;
  logic signed [LHS_W-1:0] acc_r;
  logic signed [LHS_W-1:0] rhs_r;
  logic signed [LHS_W-1:0] nrhs_r;
  logic [SPAN_W-1:0]       spd_r;
  rtc_pkg::trend_t         trend_r;
  logic                    cmp_step;
  logic signed [DIGIT_W:0] sdig;
  logic signed [LHS_W-1:0] term;
  logic signed [LHS_W-1:0] rhs_ext;

  assign cmp_step = busy_r && (cnt_r == CNT_CMP);
  assign sdig     = $signed({1'b0, spd_r[DIGIT_W-1:0]});
  assign term     = mc_r * sdig;
  assign rhs_ext  = $signed(LHS_W'({sum_x2, {rtc_pkg::FRACTION_BITS{1'b0}}}));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      busy_r <= ~cmp_step;
      cnt_r  <= cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mc_r   <= LHS_W'(sum_xy);
      acc_r  <= '0;
      spd_r  <= span;
      rhs_r  <= rhs_ext;
      nrhs_r <= -rhs_ext;
    end else if (busy_r && !cmp_step) begin
      mc_r  <= mc_r <<< DIGIT_W;
      acc_r <= acc_r + term;
      spd_r <= spd_r >> DIGIT_W;
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_step) begin
      priority if (acc_r >= rhs_r) trend_r <= rtc_pkg::TREND_RISING;
      else if (acc_r <= nrhs_r) trend_r <= rtc_pkg::TREND_FALLING;
      else trend_r <= rtc_pkg::TREND_STEADY;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = cmp_step;
  assign trend    = trend_r;

endmodule

`default_nettype wire

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for regression_trend_classifier_unit: samples in, trend words out, APB.
// Predicts each window's trend in-bench; depends on rtc_pkg, rtc_if and the RTL top.

module testbench;

  localparam int WW = rtc_pkg::WIN_W;
  localparam int SW = rtc_pkg::SAMPLE_W;
  localparam int DW = rtc_pkg::APB_DW;
  localparam int AW = rtc_pkg::APB_AW;
  localparam int SETTLE_CYCLES = 20;

  logic          clk;
  logic          rst_n;
  logic          psel;
  logic          penable;
  logic          pwrite;
  logic [AW-1:0] paddr;
  logic [DW-1:0] pwdata;
  logic [DW-1:0] prdata;
  logic          pready;

  rtc_in_if  in_ch ();
  rtc_out_if out_ch ();

  regression_trend_classifier_unit dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // window state mirrored in the bench
  logic [WW-1:0]                             win_size_reg;
  int                                        win_count;
  logic signed [rtc_pkg::COORD_W-1:0]        win_coord;
  logic signed [rtc_pkg::SXY_W-1:0]          acc_xy;
  logic [rtc_pkg::SX2_W-1:0]                 acc_x2;
  rtc_pkg::trend_t                           expected_trends[$];

  int src_idle_pct;
  int snk_stall_pct;
  int mismatches;
  int n_samples;
  int n_writes;
  int n_by_trend[3];

  always #5 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic int clamp_window(input logic [WW-1:0] ws);
    if (ws < rtc_pkg::WINDOW_MIN) return int'(rtc_pkg::WINDOW_MIN);
    if (ws > rtc_pkg::MAX_WINDOW) return rtc_pkg::MAX_WINDOW;
    return int'(ws);
  endfunction

  task automatic restart_window_model();
    int n;
    n = clamp_window(win_size_reg);
    win_count = 0;
    win_coord = rtc_pkg::COORD_W'((n % 2 == 1) ? -((n - 1) / 2) : -(n - 1));
    acc_xy = '0;
    acc_x2 = '0;
  endtask

  task automatic predict_trend(input logic signed [SW-1:0] y);
    int     n;
    int     x;
    int     span;
    longint lhs;
    longint rhs;
    n = clamp_window(win_size_reg);
    x = win_coord;
    acc_xy = acc_xy + rtc_pkg::SXY_W'(int'(y) * x);
    acc_x2 = acc_x2 + rtc_pkg::SX2_W'(x * x);
    win_count++;
    win_coord = win_coord + rtc_pkg::COORD_W'((n % 2 == 1) ? 1 : 2);
    if (win_count == n) begin
      span = (n % 2 == 1) ? n - 1 : 2 * (n - 1);
      lhs = longint'(acc_xy) * span;
      rhs = longint'(acc_x2) << rtc_pkg::FRACTION_BITS;
      if (lhs >= rhs) expected_trends.push_back(rtc_pkg::TREND_RISING);
      else if (lhs <= -rhs) expected_trends.push_back(rtc_pkg::TREND_FALLING);
      else expected_trends.push_back(rtc_pkg::TREND_STEADY);
      restart_window_model();
    end
  endtask

  always @(negedge clk) out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);

  always @(posedge clk) begin : trend_monitor
    rtc_pkg::trend_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_trends.size() == 0) begin
        report_mismatch($sformatf("trend word %0d with none due", out_ch.trend));
      end else begin
        want = expected_trends.pop_front();
        n_by_trend[want]++;
        if (out_ch.trend !== want)
          report_mismatch($sformatf("trend %0d, want %0d", out_ch.trend, want));
      end
    end
  end

  // all calls start and end at a falling edge
  task automatic send_sample(input logic signed [SW-1:0] y);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid  = 1'b1;
    in_ch.sample = y;
    do @(posedge clk); while (!in_ch.ready);
    predict_trend(y);
    n_samples++;
    @(negedge clk);
  endtask

  task automatic quiesce();
    in_ch.valid = 1'b0;
    while (expected_trends.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [AW-1:0] addr, input logic [DW-1:0] data);
    quiesce();
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = addr;
    pwdata  = data;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    if (addr == rtc_pkg::ADDR_WINDOW_SIZE) begin
      win_size_reg = data[WW-1:0];
      restart_window_model();
    end
    n_writes++;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  task automatic check_window_readback();
    logic [DW-1:0] got;
    logic [DW-1:0] want;
    want = '0;
    want[WW-1:0] = win_size_reg;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = rtc_pkg::ADDR_WINDOW_SIZE;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    if (got !== want) report_mismatch($sformatf("window_size reads %0h, want %0h", got, want));
  endtask

  // 0 full-range noise, 3 extremes, else a ramp with small noise
  function automatic logic signed [SW-1:0] shaped_sample(input int style, input int base,
                                                         input int step, input int k);
    int v;
    case (style)
      0: v = int'($urandom_range(65535)) - 32768;
      3: begin
        case ($urandom_range(4))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          3: v = -1;
          default: v = 1;
        endcase
      end
      default: v = base + step * k + int'($urandom_range(30)) - 15;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[SW-1:0];
  endfunction

  task automatic test_reset_window();
    int k;
    check_window_readback();
    for (k = 0; k < 8; k++) send_sample(SW'(-32768 + k * 9362));
  endtask

  task automatic test_threshold_edges();
    write_register(rtc_pkg::ADDR_WINDOW_SIZE, 2);
    send_sample(-32768); send_sample(32767);
    send_sample(32767);  send_sample(-32768);
    send_sample(0);      send_sample(16);
    send_sample(0);      send_sample(15);
    send_sample(16);     send_sample(0);
    send_sample(15);     send_sample(0);
  endtask

  task automatic test_odd_window();
    write_register(rtc_pkg::ADDR_WINDOW_SIZE, 3);
    check_window_readback();
    send_sample(32767);
    send_sample(0);
    send_sample(-32768);
  endtask

  task automatic test_window_restart();
    send_sample(100);
    send_sample(200);
    // unmapped address: partial window must survive
    write_register(~rtc_pkg::ADDR_WINDOW_SIZE, 32'h5);
    check_window_readback();
    send_sample(300);
    send_sample(7);
    send_sample(-7);
    // this write drops the partial window
    write_register(rtc_pkg::ADDR_WINDOW_SIZE, 2);
    send_sample(0);
    send_sample(40);
  endtask

  task automatic test_random_traffic();
    int            phase;
    int            sent;
    int            n;
    int            total;
    int            i;
    int            k;
    int            style;
    int            base;
    int            step;
    logic [DW-1:0] data;
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 48; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 48; end
        default: begin src_idle_pct = 9; snk_stall_pct = 9; end
      endcase
      sent = 0;
      while (sent < 225) begin
        data = $urandom();
        case ($urandom_range(15))
          0: data[WW-1:0] = 0;
          1: data[WW-1:0] = 1;
          2: data[WW-1:0] = 127;
          3: data[WW-1:0] = WW'(rtc_pkg::MAX_WINDOW);
          4: data[WW-1:0] = WW'(rtc_pkg::MAX_WINDOW + 1);
          default: data[WW-1:0] = WW'($urandom_range(2, 12));
        endcase
        write_register(rtc_pkg::ADDR_WINDOW_SIZE, data);
        if ($urandom_range(3) == 0) check_window_readback();
        n = clamp_window(win_size_reg);
        total = (n > 16) ? n : n * int'($urandom_range(1, 5));
        if ($urandom_range(3) == 0) total += $urandom_range(1, n - 1);
        style = 0;
        base = 0;
        step = 0;
        for (i = 0; i < total; i++) begin
          k = i % n;
          if (k == 0) begin
            style = $urandom_range(3);
            base  = int'($urandom_range(40000)) - 20000;
            step  = int'($urandom_range(48)) - 24;
          end
          send_sample(shaped_sample(style, base, step, k));
        end
        sent += total;
      end
    end
    src_idle_pct  = 0;
    snk_stall_pct = 0;
  endtask

  initial begin
    clk           = 1'b0;
    rst_n         = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    in_ch.valid   = 1'b0;
    in_ch.sample  = '0;
    out_ch.ready  = 1'b0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    mismatches    = 0;
    n_samples     = 0;
    n_writes      = 0;
    n_by_trend    = '{0, 0, 0};
    win_size_reg  = rtc_pkg::WINDOW_RESET;
    restart_window_model();
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_window();
    test_threshold_edges();
    test_odd_window();
    test_window_restart();
    test_random_traffic();
    quiesce();

    $display("Sent %0d samples over %0d register writes and four idle/stall mixes.",
             n_samples, n_writes);
    $display("Trend words checked: %0d rising, %0d steady, %0d falling; %0d mismatches.",
             n_by_trend[0], n_by_trend[1], n_by_trend[2], mismatches);
    if (mismatches == 0) begin
      $display("[regression_trend_classifier_unit] OK");
    end else begin
      $display("[regression_trend_classifier_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d trend words still due", expected_trends.size());
    $display("[regression_trend_classifier_unit] ERROR");
    $finish;
  end

endmodule
